>>> rtl/core/lru_key_value_cache_core_defines.svh
// assertion helpers for the lru key-value cache core
`ifndef LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define LKVC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define LKVC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/lkvc_pkg.sv
package lkvc_pkg;

	localparam int ENTRIES = 16;
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CAP_W = 5;
	localparam int RANK_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;
	localparam int CAPACITY_RESET = 16;

	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	localparam logic [VAL_W-1:0] MISS_VALUE = '1;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [VAL_W-1:0] val_t;
	typedef logic [RANK_W-1:0] rank_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [ENTRIES-1:0] slot_vec_t;
	typedef key_t [ENTRIES-1:0] key_array_t;
	typedef val_t [ENTRIES-1:0] val_array_t;
	typedef rank_t [ENTRIES-1:0] rank_array_t;

	typedef struct packed {
		logic hit;
		logic update;
		logic put;
		logic new_key;
		logic grow;
		slot_vec_t target;
		cnt_t thresh;
		val_t rd_data;
	} lookup_t;

endpackage

>>> rtl/core/lkvc_lookup.sv
module lkvc_lookup (
	input logic action,
	input lkvc_pkg::key_t key,
	input logic [lkvc_pkg::CAP_W-1:0] capacity,
	input lkvc_pkg::key_array_t keys,
	input lkvc_pkg::val_array_t values,
	input lkvc_pkg::slot_vec_t valid,
	input lkvc_pkg::rank_array_t ranks,
	input lkvc_pkg::cnt_t occupied,
	output lkvc_pkg::lookup_t lk
);

	lkvc_pkg::slot_vec_t match;
	lkvc_pkg::slot_vec_t oldest;
	lkvc_pkg::slot_vec_t free_vec;
	lkvc_pkg::slot_vec_t first_free;
	lkvc_pkg::val_t hit_value;
	lkvc_pkg::rank_t hit_rank;
	lkvc_pkg::cnt_t oldest_rank;
	logic [lkvc_pkg::CMP_W-1:0] cap_x;
	logic [lkvc_pkg::CMP_W-1:0] eff_cap;
	logic hit;
	logic use_free;

	assign oldest_rank = occupied - lkvc_pkg::CNT_W'(1);
	assign free_vec = ~valid;
	assign first_free = free_vec & (~free_vec + lkvc_pkg::ENTRIES'(1));
	assign hit = |match;

	always_comb begin
		match = '0;
		oldest = '0;
		hit_value = '0;
		hit_rank = '0;
		for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
			match[i] = valid[i] && (keys[i] == key);
			oldest[i] = valid[i] && (lkvc_pkg::CNT_W'(ranks[i]) == oldest_rank);
			hit_value = hit_value | ({lkvc_pkg::VAL_W{match[i]}} & values[i]);
			hit_rank = hit_rank | ({lkvc_pkg::RANK_W{match[i]}} & ranks[i]);
		end
	end

	// capacity zero acts as one, above the slot count it saturates
	always_comb begin
		cap_x = lkvc_pkg::CMP_W'(capacity);
		if (cap_x == '0) begin
			eff_cap = lkvc_pkg::CMP_W'(1);
		end else if (cap_x > lkvc_pkg::CMP_W'(lkvc_pkg::ENTRIES)) begin
			eff_cap = lkvc_pkg::CMP_W'(lkvc_pkg::ENTRIES);
		end else begin
			eff_cap = cap_x;
		end
	end

	assign use_free = lkvc_pkg::CMP_W'(occupied) < eff_cap;

	always_comb begin
		lk.hit = hit;
		lk.put = (action == lkvc_pkg::ACT_PUT);
		lk.update = hit || (action == lkvc_pkg::ACT_PUT);
		lk.new_key = (action == lkvc_pkg::ACT_PUT) && !hit;
		lk.grow = (action == lkvc_pkg::ACT_PUT) && !hit && use_free;
		if (hit) begin
			lk.target = match;
			lk.thresh = lkvc_pkg::CNT_W'(hit_rank);
		end else if (use_free) begin
			// every valid slot ages on a fresh fill
			lk.target = first_free;
			lk.thresh = occupied;
		end else begin
			lk.target = oldest;
			lk.thresh = oldest_rank;
		end
		if (action == lkvc_pkg::ACT_PUT) begin
			lk.rd_data = '0;
		end else if (hit) begin
			lk.rd_data = hit_value;
		end else begin
			lk.rd_data = lkvc_pkg::MISS_VALUE;
		end
	end

endmodule

>>> rtl/core/lkvc_store.sv
module lkvc_store (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input lkvc_pkg::key_t key,
	input lkvc_pkg::val_t value,
	input lkvc_pkg::lookup_t lk,
	output lkvc_pkg::key_array_t keys,
	output lkvc_pkg::val_array_t values,
	output lkvc_pkg::slot_vec_t valid,
	output lkvc_pkg::rank_array_t ranks,
	output lkvc_pkg::cnt_t occupied
);

	lkvc_pkg::key_array_t keys_q;
	lkvc_pkg::val_array_t values_q;
	lkvc_pkg::slot_vec_t valid_q;
	lkvc_pkg::rank_array_t ranks_q;
	lkvc_pkg::cnt_t occupied_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ranks_q <= '0;
			occupied_q <= '0;
		end else if (req_valid && lk.update) begin
			for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
				if (lk.target[i]) begin
					ranks_q[i] <= '0;
					if (lk.new_key) begin
						valid_q[i] <= 1'b1;
					end
				end else if (valid_q[i] && (lkvc_pkg::CNT_W'(ranks_q[i]) < lk.thresh)) begin
					ranks_q[i] <= ranks_q[i] + lkvc_pkg::RANK_W'(1);
				end
			end
			if (lk.grow) begin
				occupied_q <= occupied_q + lkvc_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && lk.put) begin
			for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
				if (lk.target[i]) begin
					values_q[i] <= value;
					if (lk.new_key) begin
						keys_q[i] <= key;
					end
				end
			end
		end
	end

	assign keys = keys_q;
	assign values = values_q;
	assign valid = valid_q;
	assign ranks = ranks_q;
	assign occupied = occupied_q;

endmodule

>>> rtl/core/lru_key_value_cache_core.sv
// channel   | signals                        | handshake
// request   | action, key, value             | start && !busy
// result    | hit, read_value                | done, one cycle, no back-pressure
// capacity  | cap_data                       | cap_valid && cap_ready
//
// one request per cycle, result from the result register after acceptance
// the lookup and recency update run in one pass between the request register
// and the result register, so each request sees the state the previous one left
// busy and cap_ready never deassert; no clearing pass after reset
// reset empties the cache and sets capacity to sixteen
module lru_key_value_cache_core (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic action,
	input logic signed [lkvc_pkg::KEY_W-1:0] key,
	input logic signed [lkvc_pkg::VAL_W-1:0] value,
	output logic done,
	output logic hit,
	output logic signed [lkvc_pkg::VAL_W-1:0] read_value,
	input logic cap_valid,
	output logic cap_ready,
	input logic [lkvc_pkg::CAP_W-1:0] cap_data
);

	logic valid_s1;
	logic action_s1;
	lkvc_pkg::key_t key_s1;
	lkvc_pkg::val_t value_s1;
	logic valid_s2;
	logic hit_s2;
	lkvc_pkg::val_t read_value_s2;
	logic [lkvc_pkg::CAP_W-1:0] capacity_q;

	lkvc_pkg::key_array_t keys;
	lkvc_pkg::val_array_t values;
	lkvc_pkg::slot_vec_t valid;
	lkvc_pkg::rank_array_t ranks;
	lkvc_pkg::cnt_t occupied;
	lkvc_pkg::lookup_t lk;

	assign busy = 1'b0;
	assign cap_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lkvc_pkg::CAP_W'(lkvc_pkg::CAPACITY_RESET);
		end else if (cap_valid && cap_ready) begin
			capacity_q <= cap_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			action_s1 <= action;
			key_s1 <= key;
			value_s1 <= value;
		end
		if (valid_s1) begin
			hit_s2 <= lk.hit;
			read_value_s2 <= lk.rd_data;
		end
	end

	lkvc_lookup u_lookup (
		.action(action_s1),
		.key(key_s1),
		.capacity(capacity_q),
		.keys(keys),
		.values(values),
		.valid(valid),
		.ranks(ranks),
		.occupied(occupied),
		.lk(lk)
	);

	lkvc_store u_store (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(valid_s1),
		.key(key_s1),
		.value(value_s1),
		.lk(lk),
		.keys(keys),
		.values(values),
		.valid(valid),
		.ranks(ranks),
		.occupied(occupied)
	);

	assign done = valid_s2;
	assign hit = hit_s2;
	assign read_value = read_value_s2;

endmodule

>>> rtl/core/lkvc_checker.sv
`include "lru_key_value_cache_core_defines.svh"

module lkvc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic action,
	input logic [lkvc_pkg::KEY_W-1:0] key,
	input logic [lkvc_pkg::VAL_W-1:0] value,
	input logic done,
	input logic hit,
	input logic [lkvc_pkg::VAL_W-1:0] read_value
);

	logic req;

	assign req = start && !busy;

	`LKVC_ASSERT_IMPLY(a_latency, clk, arst_n, req, ##2 done, "request without result")
	`LKVC_ASSERT_IMPLY(a_no_spurious, clk, arst_n, done, $past(req, 2), "result without request")
	`LKVC_ASSERT_IMPLY(a_put_zero, clk, arst_n, done && $past(action, 2), read_value == '0, "put returned data")
	`LKVC_ASSERT_IMPLY(a_get_miss, clk, arst_n, done && !hit && !$past(action, 2), read_value == lkvc_pkg::MISS_VALUE, "miss without miss value")
	`LKVC_ASSERT_NEXT(a_put_then_get, clk, arst_n, req && action ##1 req && !action && key == $past(key), ##1 done && hit && read_value == $past(value, 3), "get after put missed")

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.action(action),
	.key(key),
	.value(value),
	.done(done),
	.hit(hit),
	.read_value(read_value)
);
